// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// shared constants for the piecewise linear interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int COORD_W            = 32;
  localparam int PROD_W             = 2 * COORD_W;
  localparam int TOTAL_W            = 7;
  localparam int MAX_POINTS_DEFAULT = 64;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

// ----- rtl/piecewise_linear_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// breakpoint table with linear interpolation queries in signed q16.16
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An append updates the table and then
// loads its result. A query first starts the table read, then walks the
// segments in order until the bracketing one is found; the segments walked
// before it number at most the point count minus two. The walk reads one
// breakpoint per cycle from the x and y memories. After the bracketing
// segment come the 32x32 multiply, the divider launch, the bit-serial divide
// and the loading of the result. A query that finds no segment ends after the
// walk, and one on a table of fewer than two points skips the walk. A
// zero-width segment skips the multiply and the divide. A waiting result
// does not block the next accept beyond the processing of that next
// transaction.
module piecewise_linear_interpolator_core #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              operation,
  input  logic signed [pli_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pli_pkg::COORD_W-1:0] coord_y,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [pli_pkg::COORD_W-1:0] height,
  output logic                              found,
  output logic                              dropped,
  output logic signed [pli_pkg::COORD_W-1:0] left_x,
  output logic signed [pli_pkg::COORD_W-1:0] right_x,
  output logic [pli_pkg::TOTAL_W-1:0]        point_total
);

  localparam int W  = pli_pkg::COORD_W;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_FIRST, S_WALK, S_MUL, S_DIVGO, S_DIV, S_OUT
  } state_t;

  state_t                state;
  logic                  op;
  logic signed [W-1:0]   qx;
  logic signed [W-1:0]   qy;
  logic [CW-1:0]         count;
  logic [AW-1:0]         idx;
  logic signed [W-1:0]   first_x;
  logic signed [W-1:0]   last_x;
  logic signed [W-1:0]   seg_x0;
  logic signed [W-1:0]   seg_y0;
  logic [W-1:0]          seg_width;
  logic [W-1:0]          seg_run;
  logic [W-1:0]          seg_mag;
  logic                  rise_neg;
  logic [pli_pkg::PROD_W-1:0] prod;
  logic signed [W-1:0]   res_height;
  logic                  res_found;
  logic                  res_dropped;

  logic [CW-1:0]         idx_p1;
  logic                  room;
  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  logic [W-1:0]          x_rd;
  logic [W-1:0]          y_rd;
  logic signed [W-1:0]   xd;
  logic signed [W-1:0]   yd;
  logic                  hit;
  logic signed [W:0]     rise;
  logic [W:0]            rise_abs;
  logic                  div_start;
  logic                  div_done;
  logic [W-1:0]          div_quot;
  logic                  out_free;

  assign idx_p1    = CW'(idx) + 1'b1;
  assign room      = count < CW'(MAX_POINTS);
  assign wr_en     = (state == S_START) && (op == pli_pkg::OP_APPEND) && room;
  assign rd_addr   = (state == S_START) ? '0 : idx_p1[AW-1:0];
  assign xd        = $signed(x_rd);
  assign yd        = $signed(y_rd);
  assign hit       = (qx >= seg_x0) && (qx <= xd);
  assign rise      = {yd[W-1], yd} - {seg_y0[W-1], seg_y0};
  assign rise_abs  = rise[W] ? (W + 1)'(-rise) : rise;
  assign div_start = (state == S_DIVGO);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  pli_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (qx),
    .rd_addr (rd_addr),
    .rd_data (x_rd)
  );

  pli_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (qy),
    .rd_addr (rd_addr),
    .rd_data (y_rd)
  );

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (seg_width),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= operation;
            qx    <= coord_x;
            qy    <= coord_y;
            state <= S_START;
          end
        end
        S_START: begin
          res_height  <= '0;
          res_found   <= 1'b0;
          res_dropped <= 1'b0;
          idx         <= '0;
          if (op == pli_pkg::OP_APPEND) begin
            if (room) begin
              if (count == '0) begin
                first_x <= qx;
              end
              last_x <= qx;
              count  <= count + 1'b1;
            end else begin
              res_dropped <= 1'b1;
            end
            state <= S_OUT;
          end else if (count < CW'(2)) begin
            state <= S_OUT;
          end else begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          seg_x0 <= xd;
          seg_y0 <= yd;
          idx    <= '0 + AW'(1);
          state  <= S_WALK;
        end
        S_WALK: begin
          if (hit) begin
            res_found <= 1'b1;
            seg_width <= W'(xd - seg_x0);
            seg_run   <= W'(qx - seg_x0);
            seg_mag   <= rise_abs[W-1:0];
            rise_neg  <= rise[W];
            if (xd == seg_x0) begin
              res_height <= seg_y0;
              state      <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end else begin
            seg_x0 <= xd;
            seg_y0 <= yd;
            if (idx_p1 < count) begin
              idx <= idx_p1[AW-1:0];
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_MUL: begin
          prod  <= seg_mag * seg_run;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_height <= rise_neg ? seg_y0 - $signed(div_quot)
                                   : seg_y0 + $signed(div_quot);
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            height      <= res_height;
            found       <= res_found;
            dropped     <= res_dropped;
            left_x      <= (count == '0) ? '0 : first_x;
            right_x     <= (count == '0) ? '0 : last_x;
            point_total <= pli_pkg::TOTAL_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pli_ram.sv -----
// ----------------------------------------------------------------------------
// pli_ram
// generic single-write, single-read ram with a registered read port
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/pli_div.sv -----
// ----------------------------------------------------------------------------
// pli_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pli_pkg::PROD_W-1:0]  dividend,
  input  logic [pli_pkg::COORD_W-1:0] divisor,
  output logic                       done,
  output logic [pli_pkg::COORD_W-1:0] quotient
);

  localparam int W  = pli_pkg::COORD_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [W-1:0]  lo;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted  = {rem, lo[W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= dividend[pli_pkg::PROD_W-1:W];
        lo   <= dividend[W-1:0];
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? W'(shifted - {1'b0, dvs}) : shifted[W-1:0];
        lo  <= {lo[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Exercises the piecewise linear interpolator core through its request and
// response channels. A short table of directed transactions walks the empty,
// single-point, zero-width, rising, falling and out-of-range cases. Random
// traffic then builds an ascending breakpoint table until it is full, with a
// few out-of-order points and dropped appends, and queries inside it, on its
// breakpoints and anywhere in the coordinate range. Every response is
// compared field by field with the expected answer of its directed row or
// with a local model of the table and the interpolation, under several idle
// and stall patterns and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = pli_pkg::MAX_POINTS_DEFAULT;
  localparam int RANDOM_ITEMS   = 750;
  localparam int PHASE_LEN      = RANDOM_ITEMS / 4;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;

  typedef logic signed [pli_pkg::COORD_W-1:0] coord_t;

  localparam coord_t YMIN = 32'h8000_0000;
  localparam coord_t YMAX = 32'h7FFF_FFFF;
  localparam coord_t XA   = 32'hC000_0000;
  localparam coord_t XC   = 32'hE000_0000;
  localparam coord_t XD   = 32'hF000_0000;

  typedef struct packed {
    coord_t                      height;
    logic                        found;
    logic                        dropped;
    coord_t                      left_x;
    coord_t                      right_x;
    logic [pli_pkg::TOTAL_W-1:0] point_total;
  } answer_t;

  typedef struct {
    logic    op;
    coord_t  x;
    coord_t  y;
    bit      typed;
    answer_t answer;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic                        operation = pli_pkg::OP_APPEND;
  coord_t                      coord_x = '0;
  coord_t                      coord_y = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  coord_t                      height;
  logic                        found;
  logic                        dropped;
  coord_t                      left_x;
  coord_t                      right_x;
  logic [pli_pkg::TOTAL_W-1:0] point_total;

  piecewise_linear_interpolator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .height      (height),
    .found       (found),
    .dropped     (dropped),
    .left_x      (left_x),
    .right_x     (right_x),
    .point_total (point_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // breakpoint table model
  coord_t      pt_x [TABLE_DEPTH];
  coord_t      pt_y [TABLE_DEPTH];
  int unsigned pt_count = 0;
  longint      ramp_x = -64'sd268435455;

  stim_row_t   directed_rows [$];
  answer_t     pending_answers [$];
  int          mismatch_count = 0;
  bit          stimulus_done = 1'b0;

  function automatic stim_row_t mk_row(logic op, coord_t x, coord_t y, bit typed,
                                       coord_t h, logic f, coord_t l, coord_t r,
                                       int n);
    stim_row_t row;
    row.op                 = op;
    row.x                  = x;
    row.y                  = y;
    row.typed              = typed;
    row.answer.height      = h;
    row.answer.found       = f;
    row.answer.dropped     = 1'b0;
    row.answer.left_x      = l;
    row.answer.right_x     = r;
    row.answer.point_total = pli_pkg::TOTAL_W'(n);
    return row;
  endfunction

  function automatic coord_t segment_height(coord_t qx, int unsigned i);
    longint      x0, x1, y0, y1, rise, res;
    logic [63:0] span, run, mag, offset;
    x0   = pt_x[i];
    x1   = pt_x[i + 1];
    y0   = pt_y[i];
    y1   = pt_y[i + 1];
    span = x1 - x0;
    run  = longint'(qx) - x0;
    if (span == 0) return pt_y[i];
    rise   = y1 - y0;
    mag    = (rise < 0) ? -rise : rise;
    offset = (mag * run) / span;
    res    = (rise < 0) ? y0 - longint'(offset) : y0 + longint'(offset);
    return coord_t'(res);
  endfunction

  function automatic answer_t predict_answer(logic op, coord_t cx, coord_t cy);
    answer_t ans;
    ans = '0;
    if (op == pli_pkg::OP_APPEND) begin
      if (pt_count < TABLE_DEPTH) begin
        pt_x[pt_count] = cx;
        pt_y[pt_count] = cy;
        pt_count++;
      end else begin
        ans.dropped = 1'b1;
      end
    end else begin
      for (int unsigned i = 0; i + 1 < pt_count && !ans.found; i++) begin
        if (cx >= pt_x[i] && cx <= pt_x[i + 1]) begin
          ans.found  = 1'b1;
          ans.height = segment_height(cx, i);
        end
      end
    end
    if (pt_count > 0) begin
      ans.left_x  = pt_x[0];
      ans.right_x = pt_x[pt_count - 1];
    end
    ans.point_total = pli_pkg::TOTAL_W'(pt_count);
    return ans;
  endfunction

  function automatic int idle_pct(int count, bit rsp_side);
    int phase;
    phase = count / PHASE_LEN;
    if (phase > 3) phase = 3;
    case (phase)
      0:       return 0;
      1:       return rsp_side ? 0 : 56;
      2:       return rsp_side ? 56 : 0;
      default: return 15;
    endcase
  endfunction

  task automatic make_random_item(output logic op, output coord_t cx, output coord_t cy);
    int unsigned pick;
    int unsigned idx;
    longint      step, lo, hi;
    logic [63:0] span, r64;
    pick = $urandom_range(0, 99);
    cy   = $urandom;
    if (pick < ((pt_count < TABLE_DEPTH) ? 25 : 8)) begin
      op   = pli_pkg::OP_APPEND;
      pick = $urandom_range(0, 99);
      if (pick < 8) step = 0;
      else if (pick < 20) step = $urandom_range(1, 16);
      else step = $urandom_range(1, 32'h01FF_FFFF);
      if (ramp_x + step > 64'sh6FFF_FFFF) step = 0;
      ramp_x += step;
      cx   = coord_t'(ramp_x);
      pick = $urandom_range(0, 99);
      // out-of-order breakpoint
      if (pick < 8) cx = $urandom;
      if (pick >= 90) cy = pick[0] ? YMAX : YMIN;
    end else begin
      op   = pli_pkg::OP_QUERY;
      pick = $urandom_range(0, 99);
      if (pt_count < 2 || pick < 15) begin
        cx = $urandom;
      end else if (pick < 35) begin
        idx = $urandom_range(0, pt_count - 1);
        cx  = pt_x[idx] + coord_t'(int'($urandom_range(0, 2)) - 1);
      end else begin
        lo = pt_x[0];
        hi = pt_x[pt_count - 1];
        if (hi < lo) begin
          step = lo;
          lo   = hi;
          hi   = step;
        end
        span = hi - lo + 1;
        r64  = {$urandom, $urandom};
        cx   = coord_t'(lo + longint'(r64 % span));
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  // request side, prediction and response checking
  always @(posedge clk) begin : req_side
    answer_t     want;
    logic        nxt_op;
    coord_t      nxt_x, nxt_y;
    int          row_idx;
    int          random_sent;
    bit          cur_typed;
    answer_t     cur_answer;
    if (rst) begin
      req_valid   <= 1'b0;
      row_idx     = 0;
      random_sent = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: response with no pending transaction", $realtime);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          check_field("height", want.height, height);
          check_field("found", want.found, found);
          check_field("dropped", want.dropped, dropped);
          check_field("left_x", want.left_x, left_x);
          check_field("right_x", want.right_x, right_x);
          check_field("point_total", want.point_total, point_total);
        end
      end
      if (req_valid && !req_stall) begin
        want = predict_answer(operation, coord_x, coord_y);
        if (cur_typed) want = cur_answer;
        pending_answers.push_back(want);
      end
      if (!req_valid || !req_stall) begin
        if (row_idx < directed_rows.size()) begin
          req_valid  <= 1'b1;
          operation  <= directed_rows[row_idx].op;
          coord_x    <= directed_rows[row_idx].x;
          coord_y    <= directed_rows[row_idx].y;
          cur_typed  = directed_rows[row_idx].typed;
          cur_answer = directed_rows[row_idx].answer;
          row_idx++;
        end else if (random_sent < RANDOM_ITEMS) begin
          if ($urandom_range(0, 99) < idle_pct(random_sent, 1'b0)) begin
            req_valid <= 1'b0;
          end else begin
            make_random_item(nxt_op, nxt_x, nxt_y);
            req_valid <= 1'b1;
            operation <= nxt_op;
            coord_x   <= nxt_x;
            coord_y   <= nxt_y;
            cur_typed = 1'b0;
            random_sent++;
          end
        end else begin
          req_valid     <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
    end
  end

  // response side stalls, with one long hold-off
  always @(posedge clk) begin : rsp_side
    int results_taken;
    int hold_left;
    bit hold_done;
    if (rst) begin
      rsp_stall     <= 1'b0;
      results_taken = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && results_taken == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < idle_pct(results_taken, 1'b1));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : run_control
    // empty table
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, 32'h0, YMAX, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, YMIN, 32'h0, 1, 0, 0, 0, 0, 0));
    // single point
    directed_rows.push_back(mk_row(pli_pkg::OP_APPEND, XA, YMIN, 1, 0, 0, XA, XA, 1));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XA, 32'h0, 1, 0, 0, XA, XA, 1));
    // zero-width segment
    directed_rows.push_back(mk_row(pli_pkg::OP_APPEND, XA, 32'h1234, 1, 0, 0, XA, XA, 2));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XA, 32'h0, 1, YMIN, 1, XA, XA, 2));
    // rising segment across the non-negative half of the y range
    directed_rows.push_back(mk_row(pli_pkg::OP_APPEND, XC, YMAX, 1, 0, 0, XA, XC, 3));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XC, 32'h0, 1, YMAX, 1, XA, XC, 3));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XC - 1, 32'h0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, 32'hD000_0000, 32'h0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XA + 1, 32'h0, 0, 0, 0, 0, 0, 0));
    // falling segment over the full y range
    directed_rows.push_back(mk_row(pli_pkg::OP_APPEND, XD, YMIN, 1, 0, 0, XA, XD, 4));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XD, 32'h0, 1, YMIN, 1, XA, XD, 4));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, 32'hE800_0000, 32'h0, 0, 0, 0, 0, 0, 0));
    // outside the table
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, YMAX, 32'h0, 1, 0, 0, XA, XD, 4));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, YMIN, 32'h0, 1, 0, 0, XA, XD, 4));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XA - 1, 32'h0, 1, 0, 0, XA, XD, 4));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XD + 1, 32'h0, 1, 0, 0, XA, XD, 4));
    // unit-width segment, first bracketing segment wins
    directed_rows.push_back(mk_row(pli_pkg::OP_APPEND, XD + 1, 32'h0, 1, 0, 0, XA, XD + 1, 5));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XD, 32'h0, 1, YMIN, 1, XA, XD + 1, 5));
    directed_rows.push_back(mk_row(pli_pkg::OP_QUERY, XD + 1, 32'h0, 1, 0, 1, XA, XD + 1, 5));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!(stimulus_done && pending_answers.size() == 0));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
